// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files. ASSERT_CLK expects clk and arst_n in scope, ASSERT_ALWAYS clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, ignored while reset is asserted
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/tpeal_pkg.sv =====
`timescale 1ns / 1ps

package tpeal_pkg;

	// Defaults for the top-level parameters
	localparam int SAMPLE_COUNT_DEF = 64;
	localparam int ADC_BITS_DEF     = 12;

	// Fixed field widths
	localparam int ADC_IN_W   = 12;
	localparam int ADC_MAX_W  = 16;
	localparam int AVG_W      = 12;
	localparam int THR_W      = 13;
	localparam int TICK_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int NUM_CH     = 4;

	// Register reset values
	localparam logic [THR_W-1:0]  BLACK_THR_RST   = THR_W'(2048);
	localparam logic [THR_W-1:0]  GRAY_THR_RST    = THR_W'(2048);
	localparam logic [TICK_W-1:0] CYCLE_TICKS_RST = TICK_W'(5000);
	localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = TICK_W'(50);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MONITOR_ENABLE  = 3'd0,
		REG_BLACK_THRESHOLD = 3'd1,
		REG_GRAY_THRESHOLD  = 3'd2,
		REG_CYCLE_TICKS     = 3'd3,
		REG_SETTLE_TICKS    = 3'd4
	} reg_idx_t;

	// Item kinds
	localparam logic ACT_TICK   = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'b001,
		PH_EXCITING = 3'b010,
		PH_READING  = 3'b100
	} phase_t;

	typedef struct packed {
		logic                action;
		logic [ADC_IN_W-1:0] adc_black;
		logic [ADC_IN_W-1:0] adc_gray_one;
		logic [ADC_IN_W-1:0] adc_gray_two;
		logic [ADC_IN_W-1:0] adc_gray_three;
	} in_item_t;

	typedef struct packed {
		logic             excite_on;
		logic             black_full;
		logic [1:0]       gray_level;
		logic             level_update;
		logic [AVG_W-1:0] avg_black;
		logic [AVG_W-1:0] avg_gray_one;
		logic [AVG_W-1:0] avg_gray_two;
		logic [AVG_W-1:0] avg_gray_three;
	} out_item_t;

	// Sequencer settings
	typedef struct packed {
		logic              monitor_enable;
		logic [TICK_W-1:0] cycle_ticks;
		logic [TICK_W-1:0] settle_ticks;
	} seq_cfg_t;

	// Per-item status leaving the sequencer
	typedef struct packed {
		logic excite;
		logic done;
	} seq_st_t;

endpackage

// ===== sv/tank_probe_excite_average_level_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Tank probe sequencer: idle ticks, excite, settle, average SAMPLE_COUNT sample sets.
// Input channel in_valid/in_stall/in_item: one item is a millisecond tick
// (action 0) or one four-channel ADC sample set (action 1).
// Output channel out_valid/out_stall/out_item: exactly one result per item,
// in order, carrying the excite level, latest full flag, gray level, the
// averages and level_update on the item that finished a measurement.
// The item passes three registers: sequencer stage, reciprocal multiply stage
// (average = sum * constant reciprocal), threshold/output stage.
// Throughput is one item per cycle while the output is not stalled; the rate
// is set by the sequencer state update, a combinational next-state loop.
// When out_stall is high the output holds; the two stages in front keep
// filling, so up to two more items are taken before in_stall rises.
// Reset (arst_n low) puts the sequencer in idle, clears counters, sums,
// averages and flags, and loads the register defaults (disabled, thresholds
// 2048, idle limit 5000 ticks, settle limit 50 ticks).
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock edge.
module tank_probe_excite_average_level_top #(
	parameter int SAMPLE_COUNT = tpeal_pkg::SAMPLE_COUNT_DEF,
	parameter int ADC_BITS     = tpeal_pkg::ADC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  tpeal_pkg::in_item_t                in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output tpeal_pkg::out_item_t               out_item,
	input  logic                               cfg_we,
	input  logic [tpeal_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tpeal_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SUM_W   = ADC_BITS + $clog2(SAMPLE_COUNT + 1);
	localparam int L_W     = $clog2(SAMPLE_COUNT);
	localparam int SHIFT   = SUM_W + L_W;
	localparam int REC_W   = SUM_W + 1;
	localparam int PROD_W  = SUM_W + REC_W;
	// floor(2^SHIFT / N) + 1 gives an exact floor quotient for any SUM_W-bit sum
	localparam logic [63:0] RECIP = ((64'd1 << SHIFT) / 64'(SAMPLE_COUNT)) + 64'd1;

	logic                                   en_q;
	logic [tpeal_pkg::THR_W-1:0]            black_thr_q, gray_thr_q;
	logic [tpeal_pkg::TICK_W-1:0]           cycle_ticks_q, settle_ticks_q;
	tpeal_pkg::seq_cfg_t                    seq_cfg;

	logic                                   adv1, adv2, adv3, accept;
	logic                                   valid_s1, valid_s2;
	tpeal_pkg::seq_st_t                     st_s1, st_s2;
	logic [tpeal_pkg::NUM_CH-1:0][SUM_W-1:0] sums_s1;
	logic [tpeal_pkg::NUM_CH-1:0][tpeal_pkg::AVG_W-1:0] quot, quot_s2;
	logic [PROD_W-1:0]                      prod [tpeal_pkg::NUM_CH];
	logic [PROD_W-1:0]                      prod_sh [tpeal_pkg::NUM_CH];
	logic                                   full_n;
	logic [2:0]                             wet_bits;
	logic [1:0]                             wet_n;
	tpeal_pkg::out_item_t                   out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q           <= 1'b0;
			black_thr_q    <= tpeal_pkg::BLACK_THR_RST;
			gray_thr_q     <= tpeal_pkg::GRAY_THR_RST;
			cycle_ticks_q  <= tpeal_pkg::CYCLE_TICKS_RST;
			settle_ticks_q <= tpeal_pkg::SETTLE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpeal_pkg::REG_MONITOR_ENABLE:  en_q           <= cfg_data[0];
				tpeal_pkg::REG_BLACK_THRESHOLD: black_thr_q    <= cfg_data[tpeal_pkg::THR_W-1:0];
				tpeal_pkg::REG_GRAY_THRESHOLD:  gray_thr_q     <= cfg_data[tpeal_pkg::THR_W-1:0];
				tpeal_pkg::REG_CYCLE_TICKS:     cycle_ticks_q  <= cfg_data;
				tpeal_pkg::REG_SETTLE_TICKS:    settle_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign seq_cfg.monitor_enable = en_q;
	assign seq_cfg.cycle_ticks    = cycle_ticks_q;
	assign seq_cfg.settle_ticks   = settle_ticks_q;

	// Pipeline advance: a stage moves when empty or when the next one moves
	assign adv3     = !out_valid || !out_stall;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_stall = !adv1;
	assign accept   = in_valid && adv1;

	tpeal_seq #(
		.SAMPLE_COUNT(SAMPLE_COUNT),
		.ADC_BITS    (ADC_BITS),
		.SUM_W       (SUM_W)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (in_item),
		.cfg    (seq_cfg),
		.st_s1  (st_s1),
		.sums_s1(sums_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv1) begin
			valid_s1 <= in_valid;
		end
	end

	// Divide each sum by the sample count through the reciprocal
	always_comb begin
		for (int i = 0; i < tpeal_pkg::NUM_CH; i++) begin
			prod[i]    = PROD_W'(sums_s1[i]) * PROD_W'(RECIP[REC_W-1:0]);
			prod_sh[i] = prod[i] >> SHIFT;
			quot[i]    = prod_sh[i][tpeal_pkg::AVG_W-1:0];
		end
	end

	// Stage 2: averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			st_s2    <= '0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
			st_s2    <= st_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			quot_s2 <= quot;
		end
	end

	// Threshold compares
	assign full_n      = {1'b0, quot_s2[0]} < black_thr_q;
	assign wet_bits[0] = {1'b0, quot_s2[1]} < gray_thr_q;
	assign wet_bits[1] = {1'b0, quot_s2[2]} < gray_thr_q;
	assign wet_bits[2] = {1'b0, quot_s2[3]} < gray_thr_q;
	assign wet_n       = {1'b0, wet_bits[0]} + {1'b0, wet_bits[1]} + {1'b0, wet_bits[2]};

	// Stage 3: output register, which also holds the latest results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			out_q     <= '0;
		end else if (adv3) begin
			out_valid <= valid_s2;
			if (valid_s2) begin
				out_q.excite_on    <= st_s2.excite;
				out_q.level_update <= st_s2.done;
				if (st_s2.done) begin
					out_q.black_full     <= full_n;
					out_q.gray_level     <= wet_n;
					out_q.avg_black      <= quot_s2[0];
					out_q.avg_gray_one   <= quot_s2[1];
					out_q.avg_gray_two   <= quot_s2[2];
					out_q.avg_gray_three <= quot_s2[3];
				end
			end
		end
	end

	assign out_item = out_q;

	`ASSERT_CLK(a_done_drops_excite,
		(out_valid && out_item.level_update) |-> !out_item.excite_on,
		"measurement finished with excite still on")
	`ASSERT_CLK(a_disabled_no_done,
		(accept && !en_q) |=> !st_s1.done,
		"measurement finished while disabled")
	`ASSERT_ALWAYS(a_stall_blocks_input,
		(out_valid && out_stall && valid_s2 && valid_s1) |-> in_stall,
		"input taken with a full pipeline")

endmodule

// ===== sv/tpeal_seq.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpeal_seq #(
	parameter int SAMPLE_COUNT = tpeal_pkg::SAMPLE_COUNT_DEF,
	parameter int ADC_BITS     = tpeal_pkg::ADC_BITS_DEF,
	parameter int SUM_W        = ADC_BITS + $clog2(SAMPLE_COUNT + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   accept,
	input  tpeal_pkg::in_item_t                    item,
	input  tpeal_pkg::seq_cfg_t                    cfg,
	output tpeal_pkg::seq_st_t                     st_s1,
	output logic [tpeal_pkg::NUM_CH-1:0][SUM_W-1:0] sums_s1
);

	localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
	localparam logic [tpeal_pkg::ADC_MAX_W-1:0] SAMP_MASK =
		tpeal_pkg::ADC_MAX_W'((32'd1 << ADC_BITS) - 32'd1);

	tpeal_pkg::phase_t                      phase_q, phase_n;
	logic [tpeal_pkg::TICK_W-1:0]           tick_q, tick_n, tick_inc, limit;
	logic [CNT_W-1:0]                       cnt_q, cnt_n, cnt_inc;
	logic [tpeal_pkg::NUM_CH-1:0][SUM_W-1:0] sums_q, sums_n;
	logic [tpeal_pkg::NUM_CH-1:0][tpeal_pkg::ADC_IN_W-1:0] samp;
	logic                                   done;

	assign samp[0] = item.adc_black;
	assign samp[1] = item.adc_gray_one;
	assign samp[2] = item.adc_gray_two;
	assign samp[3] = item.adc_gray_three;

	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;
	assign limit    = (phase_q == tpeal_pkg::PH_IDLE) ? cfg.cycle_ticks : cfg.settle_ticks;
	assign cnt_inc  = cnt_q + 1'b1;

	// Next state for one item
	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		cnt_n   = cnt_q;
		sums_n  = sums_q;
		done    = 1'b0;
		if (cfg.monitor_enable) begin
			if (item.action == tpeal_pkg::ACT_TICK) begin
				if (phase_q != tpeal_pkg::PH_READING) begin
					tick_n = tick_inc;
					if (tick_inc >= limit) begin
						tick_n = '0;
						if (phase_q == tpeal_pkg::PH_IDLE) begin
							phase_n = tpeal_pkg::PH_EXCITING;
						end else begin
							phase_n = tpeal_pkg::PH_READING;
							cnt_n   = '0;
							sums_n  = '0;
						end
					end
				end
			end else if (phase_q == tpeal_pkg::PH_READING) begin
				for (int i = 0; i < tpeal_pkg::NUM_CH; i++) begin
					sums_n[i] = sums_q[i] + SUM_W'(tpeal_pkg::ADC_MAX_W'(samp[i]) & SAMP_MASK);
				end
				cnt_n = cnt_inc;
				if (cnt_inc >= CNT_W'(SAMPLE_COUNT)) begin
					done    = 1'b1;
					cnt_n   = '0;
					tick_n  = '0;
					phase_n = tpeal_pkg::PH_IDLE;
				end
			end
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tpeal_pkg::PH_IDLE;
			tick_q  <= '0;
			cnt_q   <= '0;
			sums_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			cnt_q   <= cnt_n;
			sums_q  <= sums_n;
		end
	end

	// Stage 1 status and the sums including this item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
		end else if (accept) begin
			st_s1.excite <= (phase_n != tpeal_pkg::PH_IDLE);
			st_s1.done   <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sums_s1 <= sums_n;
		end
	end

	`ASSERT_CLK(a_cnt_only_reading,
		(cnt_q != '0) |-> (phase_q == tpeal_pkg::PH_READING),
		"sample count running outside reading")
	`ASSERT_CLK(a_tick_not_reading,
		(tick_q != '0) |-> (phase_q != tpeal_pkg::PH_READING),
		"tick count running during reading")
	`ASSERT_CLK(a_done_in_reading,
		done |-> (phase_q == tpeal_pkg::PH_READING),
		"measurement finished outside reading")

endmodule

// ===== verif/tank_probe_excite_average_level_top_tb.sv =====
`timescale 1ns / 1ps

module tank_probe_excite_average_level_top_tb;
	import tpeal_pkg::*;

	localparam int SETS        = SAMPLE_COUNT_DEF;
	localparam int PIPE_DEPTH  = 3;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int PHASE_ITEMS = 220;

	// Level predictor and queue of expected results
	class level_scoreboard;
		phase_t            phase;
		logic [TICK_W-1:0] ticks;
		int                sets_taken;
		logic [17:0]       sums [NUM_CH];
		logic [AVG_W-1:0]  avgs [NUM_CH];
		logic              full;
		logic [1:0]        wet;

		logic              enable;
		logic [THR_W-1:0]  black_thr;
		logic [THR_W-1:0]  gray_thr;
		logic [TICK_W-1:0] cycle_lim;
		logic [TICK_W-1:0] settle_lim;

		out_item_t         expected_q [$];
		int                errors;
		int                measurements;
		int                results;

		function new();
			phase      = PH_IDLE;
			ticks      = '0;
			sets_taken = 0;
			for (int i = 0; i < NUM_CH; i++) begin
				sums[i] = '0;
				avgs[i] = '0;
			end
			full       = 1'b0;
			wet        = 2'd0;
			enable     = 1'b0;
			black_thr  = BLACK_THR_RST;
			gray_thr   = GRAY_THR_RST;
			cycle_lim  = CYCLE_TICKS_RST;
			settle_lim = SETTLE_TICKS_RST;
			errors       = 0;
			measurements = 0;
			results      = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_MONITOR_ENABLE:  enable     = d[0];
				REG_BLACK_THRESHOLD: black_thr  = d[THR_W-1:0];
				REG_GRAY_THRESHOLD:  gray_thr   = d[THR_W-1:0];
				REG_CYCLE_TICKS:     cycle_lim  = d;
				REG_SETTLE_TICKS:    settle_lim = d;
				default: ;
			endcase
		endfunction

		// Advance the sequencer by one accepted item and queue its result
		function void note_input(in_item_t it);
			out_item_t         want;
			logic              done;
			logic [TICK_W-1:0] lim;
			logic [1:0]        cnt;
			done = 1'b0;
			if (enable) begin
				if (it.action == ACT_TICK) begin
					if (phase != PH_READING) begin
						lim = (phase == PH_IDLE) ? cycle_lim : settle_lim;
						if (ticks != '1)
							ticks++;
						if (ticks >= lim) begin
							ticks = '0;
							if (phase == PH_IDLE) begin
								phase = PH_EXCITING;
							end else begin
								phase      = PH_READING;
								sets_taken = 0;
								for (int i = 0; i < NUM_CH; i++)
									sums[i] = '0;
							end
						end
					end
				end else if (phase == PH_READING) begin
					sums[0] += it.adc_black;
					sums[1] += it.adc_gray_one;
					sums[2] += it.adc_gray_two;
					sums[3] += it.adc_gray_three;
					sets_taken++;
					if (sets_taken >= SETS) begin
						// measurement complete: averages, flag, wetted count
						for (int i = 0; i < NUM_CH; i++)
							avgs[i] = AVG_W'(sums[i] / SETS);
						full = ({1'b0, avgs[0]} < black_thr);
						cnt = 2'd0;
						for (int i = 1; i < NUM_CH; i++)
							if ({1'b0, avgs[i]} < gray_thr)
								cnt++;
						wet   = cnt;
						ticks = '0;
						phase = PH_IDLE;
						done  = 1'b1;
						measurements++;
					end
				end
			end
			want.excite_on      = (phase != PH_IDLE);
			want.black_full     = full;
			want.gray_level     = wet;
			want.level_update   = done;
			want.avg_black      = avgs[0];
			want.avg_gray_one   = avgs[1];
			want.avg_gray_two   = avgs[2];
			want.avg_gray_three = avgs[3];
			expected_q.push_back(want);
		endfunction

		function void compare(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			results++;
			compare("excite_on", want.excite_on, got.excite_on);
			compare("black_full", want.black_full, got.black_full);
			compare("gray_level", want.gray_level, got.gray_level);
			compare("level_update", want.level_update, got.level_update);
			compare("avg_black", want.avg_black, got.avg_black);
			compare("avg_gray_one", want.avg_gray_one, got.avg_gray_one);
			compare("avg_gray_two", want.avg_gray_two, got.avg_gray_two);
			compare("avg_gray_three", want.avg_gray_three, got.avg_gray_three);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_item;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_item;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	level_scoreboard sb;
	int              send_gap_pct;
	int              recv_stall_pct;
	int              cycles;
	int              items_sent;
	int              settings_used;
	logic [ADC_IN_W-1:0] level_base [NUM_CH];
	logic                level_noisy [NUM_CH];

	tank_probe_excite_average_level_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tank_probe_excite_average_level_top: mismatch");
			$finish;
		end
	end

	// Result side: check each accepted item, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_item);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic in_item_t make_item(logic act, logic [11:0] b, logic [11:0] g1,
		logic [11:0] g2, logic [11:0] g3);
		in_item_t it;
		it.action         = act;
		it.adc_black      = b;
		it.adc_gray_one   = g1;
		it.adc_gray_two   = g2;
		it.adc_gray_three = g3;
		return it;
	endfunction

	function automatic logic [THR_W-1:0] pick_threshold();
		case ($urandom_range(3))
			0: return '0;
			1: return THR_W'(4096);
			default: return THR_W'($urandom_range(4096));
		endcase
	endfunction

	// Per-measurement channel levels: rails, either side of the threshold, or random
	function automatic void pick_levels();
		logic [THR_W-1:0] thr;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			thr = (ch == 0) ? sb.black_thr : sb.gray_thr;
			case ($urandom_range(4))
				0: level_base[ch] = '0;
				1: level_base[ch] = '1;
				2: level_base[ch] = (thr == 0) ? '0 : (thr > 4096) ? '1 : ADC_IN_W'(thr - 1);
				3: level_base[ch] = (thr > 4095) ? '1 : ADC_IN_W'(thr);
				default: level_base[ch] = ADC_IN_W'($urandom_range(4095));
			endcase
			level_noisy[ch] = ($urandom_range(9) < 3);
		end
	endfunction

	function automatic logic [11:0] level_sample(int ch);
		return level_noisy[ch] ? 12'($urandom_range(4095)) : level_base[ch];
	endfunction

	// Mostly the item the sequencer wants next; the rest are stray ticks or samples
	function automatic in_item_t next_item();
		logic want_sample;
		logic proper;
		proper = ($urandom_range(99) < 85);
		want_sample = (sb.phase == PH_READING) ? proper : !proper;
		if (!want_sample) begin
			if (sb.phase != PH_READING)
				pick_levels();
			return make_item(ACT_TICK, 12'($urandom), 12'($urandom), 12'($urandom),
				12'($urandom));
		end
		return make_item(ACT_SAMPLE, level_sample(0), level_sample(1), level_sample(2),
			level_sample(3));
	endfunction

	task automatic send(in_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(it);
		items_sent++;
	endtask

	// Let every outstanding result come back, then let the pipeline go quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		sb.set_reg(idx, d);
	endtask

	task automatic configure(logic en, logic [THR_W-1:0] blk, logic [THR_W-1:0] gry,
		logic [TICK_W-1:0] cyc, logic [TICK_W-1:0] stl);
		put_reg(REG_MONITOR_ENABLE, CFG_DATA_W'(en));
		put_reg(REG_BLACK_THRESHOLD, CFG_DATA_W'(blk));
		put_reg(REG_GRAY_THRESHOLD, CFG_DATA_W'(gry));
		put_reg(REG_CYCLE_TICKS, cyc);
		put_reg(REG_SETTLE_TICKS, stl);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		sb             = new();
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_item        = '0;
		out_stall      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cycles         = 0;
		items_sent     = 0;
		settings_used  = 0;
		send_gap_pct   = 26;
		recv_stall_pct = 57;
		pick_levels();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: disabled after reset, then each phase step with zero tick limits
		send(make_item(ACT_TICK, '0, '0, '0, '0));
		send(make_item(ACT_SAMPLE, '1, '1, '1, '1));
		drain();
		configure(1'b1, THR_W'(4096), '0, '0, '0);
		send(make_item(ACT_SAMPLE, '1, '0, '1, '0));
		send(make_item(ACT_TICK, '1, '1, '1, '1));
		send(make_item(ACT_SAMPLE, '0, '1, '0, '1));
		send(make_item(ACT_TICK, '0, '0, '0, '0));
		send(make_item(ACT_TICK, '1, '1, '1, '1));
		send(make_item(ACT_SAMPLE, '1, '1, '1, '1));
		send(make_item(ACT_SAMPLE, '0, '0, '0, '0));
		send(make_item(ACT_SAMPLE, 12'h555, 12'haaa, 12'h555, 12'haaa));
		drain();

		// Random phases; a disabled phase may freeze a measurement midway
		for (int p = 1; p <= 9; p++) begin
			if (p == 4) begin
				send_gap_pct   = 57;
				recv_stall_pct = 26;
			end else if (p == 7) begin
				send_gap_pct   = 0;
				recv_stall_pct = 0;
			end
			case (p)
				1: configure(1'b1, '0, THR_W'(4096), TICK_W'(1), '0);
				2: configure(1'b1, THR_W'(4096), THR_W'(4096), '0, TICK_W'(3));
				3: configure(1'b0, THR_W'(2048), '0, TICK_W'(2), TICK_W'(2));
				default: configure($urandom_range(5) != 0, pick_threshold(), pick_threshold(),
					TICK_W'($urandom_range(6)), TICK_W'($urandom_range(6)));
			endcase
			repeat (PHASE_ITEMS) send(next_item());
			drain();
		end

		$display("%0d items sent over %0d register settings, %0d results checked,",
			items_sent, settings_used, sb.results);
		$display("%0d measurements completed among stray ticks, stray samples and frozen phases",
			sb.measurements);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("tank_probe_excite_average_level_top: match");
		else
			$display("tank_probe_excite_average_level_top: mismatch");
		$finish;
	end

endmodule

// ===== tank_probe_excite_average_level_top.f =====
+incdir+sv
sv/tpeal_pkg.sv
sv/tpeal_seq.sv
sv/tank_probe_excite_average_level_top.sv
verif/tank_probe_excite_average_level_top_tb.sv
